### rtl/qssd_pkg.sv
// shared types, constants and helpers for the query string splitter
package qssd_pkg;

  localparam int QueueDepthDefault = 4;
  localparam int MaxResults = 3;

  // result kinds
  localparam logic [1:0] KindKey   = 2'd0;
  localparam logic [1:0] KindValue = 2'd1;
  localparam logic [1:0] KindEnd   = 2'd2;
  localparam logic [1:0] KindDone  = 2'd3;

  // escape phases
  localparam logic [1:0] EscNone = 2'd0;
  localparam logic [1:0] EscHigh = 2'd1;
  localparam logic [1:0] EscLow  = 2'd2;

  // register indexes
  localparam logic [1:0] RegMaxParams = 2'd0;
  localparam logic [1:0] RegKeyCap    = 2'd1;
  localparam logic [1:0] RegValueCap  = 2'd2;

  localparam logic [7:0]  MaxParamsReset = 8'd16;
  localparam logic [12:0] KeyCapReset    = 13'd64;
  localparam logic [12:0] ValueCapReset  = 13'd256;
  localparam logic [12:0] CapLimit       = 13'd4096;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChEquals  = 8'h3d;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] HexAlpha  = 8'd10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] index;
    logic       has_value;
    logic       status;
  } result_t;

  // results caused by one byte, in delivery order
  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [1:0]               count;
  } bundle_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    if (b >= 8'h30 && b <= 8'h39) v = b - 8'h30;
    else if (b >= 8'h61 && b <= 8'h66) v = b - 8'h61 + HexAlpha;
    else if (b >= 8'h41 && b <= 8'h46) v = b - 8'h41 + HexAlpha;
    else v = 8'd0;
    return v[3:0];
  endfunction

endpackage

### rtl/qssd_in_if.sv
// input byte channel
interface qssd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       final_byte;
  modport source(output valid, raw_byte, final_byte, input ready);
  modport sink(input valid, raw_byte, final_byte, output ready);
endinterface

### rtl/qssd_out_if.sv
// result channel
interface qssd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic [7:0] index;
  logic       has_value;
  logic       status;
  logic       run_end;
  modport source(output valid, kind, data, index, has_value, status, run_end, input ready);
  modport sink(input valid, kind, data, index, has_value, status, run_end, output ready);
endinterface

### rtl/qssd_cfg_if.sv
// configuration write channel
interface qssd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/qssd_front.sv
// front end: config registers, byte classification, decode state, result bundling
module qssd_front
  import qssd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  qssd_in_if.sink   query,
  qssd_cfg_if.sink  cfg,
  input  logic      queue_full,
  output logic      push_valid,
  output bundle_t   push_bundle
);

  logic [7:0]  param_limit;
  logic [12:0] key_cap;
  logic [12:0] value_cap;

  logic        seg_phase;
  logic [1:0]  esc_phase;
  logic [3:0]  high_nib;
  logic [11:0] dec_len;
  logic [7:0]  param_count;
  logic        rejected;

  logic        seg_phase_next;
  logic [1:0]  esc_phase_next;
  logic [3:0]  high_nib_next;
  logic [11:0] dec_len_next;
  logic [7:0]  param_count_next;
  logic        rejected_next;

  logic        accept;
  logic [1:0]  n;
  logic        ended;
  logic [12:0] cap;
  logic [7:0]  plain;
  bundle_t     bundle;

  assign query.ready = !queue_full;
  assign cfg.ready   = 1'b1;
  assign accept      = query.valid && query.ready;

  function automatic result_t mk_byte(input logic ph, input logic [7:0] d,
                                      input logic [7:0] idx);
    result_t r;
    r = '0;
    r.kind  = ph ? KindValue : KindKey;
    r.data  = d;
    r.index = idx;
    return r;
  endfunction

  function automatic result_t mk_end(input logic ph, input logic [7:0] idx);
    result_t r;
    r = '0;
    r.kind      = KindEnd;
    r.index     = idx;
    r.has_value = ph;
    return r;
  endfunction

  always_comb begin
    seg_phase_next   = seg_phase;
    esc_phase_next   = esc_phase;
    high_nib_next    = high_nib;
    dec_len_next     = dec_len;
    param_count_next = param_count;
    rejected_next    = rejected;
    bundle           = '0;
    n                = 2'd0;
    ended            = 1'b0;
    cap              = seg_phase ? value_cap : key_cap;
    if (cap > CapLimit) cap = CapLimit;
    plain = (query.raw_byte == ChPlus) ? ChSpace : query.raw_byte;

    if (!rejected && param_count < param_limit) begin
      if (esc_phase == EscHigh) begin
        if (!is_hex(query.raw_byte)) rejected_next = 1'b1;
        else begin
          high_nib_next  = hex_value(query.raw_byte);
          esc_phase_next = EscLow;
        end
      end else if (esc_phase == EscLow) begin
        if (!is_hex(query.raw_byte)) rejected_next = 1'b1;
        else begin
          esc_phase_next = EscNone;
          bundle.res[n]  = mk_byte(seg_phase, {high_nib, hex_value(query.raw_byte)},
                                   param_count);
          n              = n + 2'd1;
          dec_len_next   = dec_len + 12'd1;
          high_nib_next  = 4'd0;
        end
      end else if (query.raw_byte == ChAmp) begin
        bundle.res[n]    = mk_end(seg_phase, param_count);
        n                = n + 2'd1;
        param_count_next = param_count + 8'd1;
        seg_phase_next   = 1'b0;
        esc_phase_next   = EscNone;
        high_nib_next    = 4'd0;
        dec_len_next     = 12'd0;
        ended            = 1'b1;
      end else if (query.raw_byte == ChEquals && !seg_phase) begin
        seg_phase_next = 1'b1;
        dec_len_next   = 12'd0;
      end else if ({1'b0, dec_len} + 13'd1 >= cap) begin
        rejected_next = 1'b1;
      end else if (query.raw_byte == ChPercent) begin
        esc_phase_next = EscHigh;
      end else begin
        bundle.res[n] = mk_byte(seg_phase, plain, param_count);
        n             = n + 2'd1;
        dec_len_next  = dec_len + 12'd1;
      end

      // final byte closes the open parameter unless rejected or already closed by an ampersand; an open escape rejects
      if (query.final_byte && !rejected_next && !ended) begin
        if (esc_phase_next != EscNone) rejected_next = 1'b1;
        else begin
          bundle.res[n]    = mk_end(seg_phase_next, param_count_next);
          n                = n + 2'd1;
          param_count_next = param_count_next + 8'd1;
        end
      end
    end

    if (query.final_byte) begin
      bundle.res[n]        = '0;
      bundle.res[n].kind   = KindDone;
      bundle.res[n].index  = param_count_next;
      bundle.res[n].status = rejected_next;
      n                    = n + 2'd1;
      seg_phase_next       = 1'b0;
      esc_phase_next       = EscNone;
      high_nib_next        = 4'd0;
      dec_len_next         = 12'd0;
      param_count_next     = 8'd0;
      rejected_next        = 1'b0;
    end
    bundle.count = n;
  end

  assign push_valid  = accept && (n != 2'd0);
  assign push_bundle = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      param_limit <= MaxParamsReset;
      key_cap     <= KeyCapReset;
      value_cap   <= ValueCapReset;
      seg_phase   <= 1'b0;
      esc_phase   <= EscNone;
      high_nib    <= 4'd0;
      dec_len     <= 12'd0;
      param_count <= 8'd0;
      rejected    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          RegMaxParams: param_limit <= cfg.data[7:0];
          RegKeyCap:    key_cap     <= cfg.data;
          RegValueCap:  value_cap   <= cfg.data;
          default: ;
        endcase
      end
      if (accept) begin
        seg_phase   <= seg_phase_next;
        esc_phase   <= esc_phase_next;
        high_nib    <= high_nib_next;
        dec_len     <= dec_len_next;
        param_count <= param_count_next;
        rejected    <= rejected_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && query.final_byte) |=>
      (param_count == 8'd0 && !rejected && esc_phase == EscNone && dec_len == 12'd0))
    else $error("query state not cleared after final byte");

  a_final_done_last: assert property (@(posedge clk) disable iff (rst)
    (accept && query.final_byte) |->
      (push_valid && push_bundle.res[push_bundle.count - 2'd1].kind == KindDone))
    else $error("final byte did not end with query done");
`endif

endmodule

### rtl/qssd_queue.sv
// small queue of result bundles between front and back
module qssd_queue
  import qssd_pkg::*;
#(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_bundle,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && full) |-> pop)
    else $error("bundle pushed into full queue");
`endif

endmodule

### rtl/qssd_back.sv
// back end: hands out the results of each bundle one per cycle while the result output is ready
module qssd_back
  import qssd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  bundle_t   head,
  output logic      pop,
  qssd_out_if.source result
);

  logic [1:0] sub;
  logic       last;
  result_t    cur;

  assign cur  = head.res[sub];
  assign last = (sub == head.count - 2'd1);

  assign result.valid     = head_valid;
  assign result.kind      = cur.kind;
  assign result.data      = cur.data;
  assign result.index     = cur.index;
  assign result.has_value = cur.has_value;
  assign result.status    = cur.status;
  assign result.run_end   = last;

  assign pop = result.valid && result.ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 2'd0;
    end else if (result.valid && result.ready) begin
      sub <= last ? 2'd0 : sub + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_sub_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (sub < head.count))
    else $error("result position beyond bundle");
`endif

endmodule

### rtl/query_string_splitter_decoder.sv
// top level of the query string splitter and percent decoder
// the results of a byte enter the bundle queue and are offered once earlier ones drain
// throughput, with the output ready: one byte per cycle while each byte yields at most
//   one result; else the single port paces one result per cycle, up to three per byte
// the bundle queue lets bytes keep flowing while results wait on the output
// reset (rst, synchronous): registers to defaults, query state cleared, queue empty
module query_string_splitter_decoder
  import qssd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  qssd_in_if.sink    query,
  qssd_cfg_if.sink   cfg,
  qssd_out_if.source result
);

  logic    queue_full;
  logic    push_valid;
  bundle_t push_bundle;
  logic    pop;
  logic    head_valid;
  bundle_t head;

  qssd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .query       (query),
    .cfg         (cfg),
    .queue_full  (queue_full),
    .push_valid  (push_valid),
    .push_bundle (push_bundle)
  );

  qssd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push_valid),
    .push_bundle (push_bundle),
    .full        (queue_full),
    .pop         (pop),
    .head_valid  (head_valid),
    .head        (head)
  );

  qssd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule
